// ===== rtl/jse_pkg.sv =====
// shared types, character codes and helpers for the json string escaper
`timescale 1ns / 1ps
package jse_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_PLAIN   = 2'd1;
   localparam logic [1:0] KIND_SHORT   = 2'd2;
   localparam logic [1:0] KIND_UNICODE = 2'd3;

   localparam logic [15:0] QUOTE_CH   = 16'h0022;
   localparam logic [15:0] BSLASH_CH  = 16'h005C;
   localparam logic [15:0] SOLIDUS_CH = 16'h002F;
   localparam logic [15:0] BSPACE_CH  = 16'h0008;
   localparam logic [15:0] FFEED_CH   = 16'h000C;
   localparam logic [15:0] NLINE_CH   = 16'h000A;
   localparam logic [15:0] CRET_CH    = 16'h000D;
   localparam logic [15:0] TAB_CH     = 16'h0009;
   localparam logic [15:0] CTRL_LIMIT = 16'h0020;
   localparam logic [15:0] LET_B_CH   = 16'h0062;
   localparam logic [15:0] LET_F_CH   = 16'h0066;
   localparam logic [15:0] LET_N_CH   = 16'h006E;
   localparam logic [15:0] LET_R_CH   = 16'h0072;
   localparam logic [15:0] LET_T_CH   = 16'h0074;
   localparam logic [15:0] LET_U_CH   = 16'h0075;
   localparam logic [15:0] DIGIT0_CH  = 16'h0030;
   localparam logic [15:0] ALPHA_BASE = 16'h0037;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        first_unit;
      logic        last_unit;
      logic        no_unit;
   } req_type;

   typedef struct packed {
      logic [15:0] out_char;
      logic        run_end;
      logic        string_end;
   } rsp_type;

   typedef struct packed {
      logic        first;
      logic        last;
      logic [1:0]  kind;
      logic [15:0] chr;
   } desc_type;

   function automatic logic [15:0] hex_char(input logic [3:0] digit);
      if (digit < 4'd10) begin
         return DIGIT0_CH + 16'(digit);
      end
      return ALPHA_BASE + 16'(digit);
   endfunction

endpackage

// ===== rtl/jse_front.sv =====
// front end: masks the code unit and classifies it into an expansion descriptor
`timescale 1ns / 1ps
module jse_front import jse_pkg::*; #(
   parameter int UNIT_BITS = 16
) (
   input  req_type  req_data,
   input  logic     req_valid,
   input  logic     queue_full,
   output logic     req_stall,
   output logic     push,
   output desc_type push_desc
);

   logic [15:0] unit;
   logic [15:0] esc;

   assign unit = 16'(req_data.code_unit[UNIT_BITS-1:0]);

   always_comb begin
      esc = unit;
      case (unit)
         QUOTE_CH, BSLASH_CH, SOLIDUS_CH: esc = unit;
         BSPACE_CH: esc = LET_B_CH;
         FFEED_CH:  esc = LET_F_CH;
         NLINE_CH:  esc = LET_N_CH;
         CRET_CH:   esc = LET_R_CH;
         TAB_CH:    esc = LET_T_CH;
         default:   esc = unit;
      endcase
   end

   always_comb begin
      push_desc.first = req_data.first_unit;
      push_desc.last  = req_data.last_unit;
      push_desc.chr   = esc;
      if (req_data.no_unit) begin
         push_desc.kind = KIND_NONE;
      end else begin
         case (unit)
            QUOTE_CH, BSLASH_CH, SOLIDUS_CH, BSPACE_CH, FFEED_CH, NLINE_CH, CRET_CH,
            TAB_CH: push_desc.kind = KIND_SHORT;
            default: begin
               if (unit < CTRL_LIMIT) begin
                  push_desc.kind = KIND_UNICODE;
               end else begin
                  push_desc.kind = KIND_PLAIN;
               end
            end
         endcase
      end
   end

   assign req_stall = queue_full;
   assign push = req_valid && !queue_full &&
                 (req_data.first_unit || req_data.last_unit || !req_data.no_unit);

endmodule

// ===== rtl/jse_queue.sv =====
// short descriptor queue between front and back
`timescale 1ns / 1ps
module jse_queue import jse_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output desc_type head
);

   desc_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

// ===== rtl/jse_back.sv =====
// back end: walks one descriptor into rsp_ff a character per cycle unless stalled
`timescale 1ns / 1ps
module jse_back import jse_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  desc_type head,
   input  logic     empty,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [2:0] body_len;
   logic [3:0] total;
   logic [2:0] k;
   logic [15:0] body_char;
   logic       out_ready;
   logic       emit;
   logic       last_step;

   always_comb begin
      case (head.kind)
         KIND_PLAIN:   body_len = 3'd1;
         KIND_SHORT:   body_len = 3'd2;
         KIND_UNICODE: body_len = 3'd6;
         default:      body_len = 3'd0;
      endcase
   end

   assign total     = 4'(body_len) + 4'(head.first) + 4'(head.last);
   assign k         = step_ff - 3'(head.first);
   assign last_step = (4'(step_ff) == total - 4'd1);

   always_comb begin
      body_char = head.chr;
      case (head.kind)
         KIND_SHORT: body_char = (k == 3'd0) ? BSLASH_CH : head.chr;
         KIND_UNICODE: begin
            case (k)
               3'd0:    body_char = BSLASH_CH;
               3'd1:    body_char = LET_U_CH;
               3'd2:    body_char = DIGIT0_CH;
               3'd3:    body_char = DIGIT0_CH;
               3'd4:    body_char = hex_char(head.chr[7:4]);
               default: body_char = hex_char(head.chr[3:0]);
            endcase
         end
         default: body_char = head.chr;
      endcase
   end

   always_comb begin
      rsp_in.run_end = last_step;
      if (head.first && step_ff == 3'd0) begin
         rsp_in.out_char   = QUOTE_CH;
         rsp_in.string_end = 1'b0;
      end else if (4'(k) < 4'(body_len)) begin
         rsp_in.out_char   = body_char;
         rsp_in.string_end = 1'b0;
      end else begin
         rsp_in.out_char   = QUOTE_CH;
         rsp_in.string_end = 1'b1;
      end
   end

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign emit      = !empty && out_ready;
   assign pop       = emit && last_step;

   always_comb begin
      step_in = step_ff;
      if (emit) begin
         step_in = last_step ? 3'd0 : step_ff + 3'd1;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_step_in_run: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (4'(step_ff) < total))
      else $error("expansion step beyond run length");

   a_close_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.string_end) |-> (rsp_data.run_end && rsp_data.out_char == QUOTE_CH))
      else $error("closing quote not at end of run");

   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      empty |-> (step_ff == 3'd0))
      else $error("step left mid-run with queue empty");

endmodule

// ===== rtl/json_string_escaper.sv =====
// top level of the json string escaper
// Takes one code unit per transfer and returns the JSON-quoted text one character per
// transfer. An unescaped string streams at one unit per cycle while rsp_stall is low; the
// output side emits from 1 to 8 characters per unit (quotes, a two-character escape, or a
// six-character \u escape), and its one-character-per-cycle output sequencer sets the
// sustained rate. A four-entry descriptor queue sits between the classifier and the
// sequencer, so req_stall rises only when it fills. Units carrying nothing to emit are
// taken and dropped. The last character of each unit's run has run_end set, a closing
// quote has string_end set. No state is kept between units.
`timescale 1ns / 1ps
module json_string_escaper import jse_pkg::*; #(
   parameter int CHAR_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int UNIT_BITS = (CHAR_BITS < 16) ? CHAR_BITS : 16;

   logic     push;
   logic     pop;
   logic     full;
   logic     empty;
   desc_type push_desc;
   desc_type head;

   jse_front #(
      .UNIT_BITS(UNIT_BITS)
   ) u_front (
      .req_data  (req_data),
      .req_valid (req_valid),
      .queue_full(full),
      .req_stall (req_stall),
      .push      (push),
      .push_desc (push_desc)
   );

   jse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_desc(push_desc),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   jse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .empty    (empty),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
